// File: hdl/alt_pkg.sv
// Shared types, constants and character class helpers for the assembly line tokenizer.
`timescale 1ns / 1ps

package alt_pkg;

  localparam int unsigned TEXT_BYTES = 32;
  localparam int unsigned TEXT_CW    = $clog2(TEXT_BYTES);

  localparam logic [7:0] LIMIT_RESET = 8'd16;

  localparam logic [7:0] CH_NUL   = 8'h00;
  localparam logic [7:0] CH_COMMA = 8'h2C;
  localparam logic [7:0] CH_COLON = 8'h3A;
  localparam logic [7:0] CH_UNDER = 8'h5F;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_LOW_X = 8'h78;
  localparam logic [7:0] CH_UP_X  = 8'h58;
  localparam logic [7:0] CH_MINUS = 8'h2D;

  typedef enum logic [1:0] {
    TK_IDENT  = 2'd0,
    TK_NUMBER = 2'd1,
    TK_COMMA  = 2'd2,
    TK_COLON  = 2'd3
  } tok_kind_e;

  typedef enum logic {
    IK_TOKEN   = 1'b0,
    IK_SUMMARY = 1'b1
  } item_kind_e;

  typedef struct packed {
    item_kind_e item_kind;
    tok_kind_e  token_kind;
    logic [7:0] text_byte;
    logic       token_first;
    logic       token_final;
    logic [7:0] token_number;
    logic [7:0] token_total;
    logic       run_last;
  } result_t;

  typedef struct packed {
    logic [1:0] count;
    result_t    r0;
    result_t    r1;
  } emit_t;

  function automatic logic is_letter(input logic [7:0] c);
    return c inside {[8'h61:8'h7A], [8'h41:8'h5A]};
  endfunction

  function automatic logic is_dec(input logic [7:0] c);
    return c inside {[8'h30:8'h39]};
  endfunction

  function automatic logic is_hexd(input logic [7:0] c);
    return c inside {[8'h30:8'h39], [8'h61:8'h66], [8'h41:8'h46]};
  endfunction

endpackage

// File: hdl/alt_lexer.sv
// Scanner state and per-character token result generation.
`timescale 1ns / 1ps

module alt_lexer import alt_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       cfg_we_i,
  input  logic [7:0] cfg_wdata_i,
  input  logic       accept_i,
  input  logic [7:0] char_i,
  output emit_t      emit_o
);

  typedef enum logic [2:0] {
    M_IDLE  = 3'd0,
    M_MINUS = 3'd1,
    M_IDENT = 3'd2,
    M_ZERO  = 3'd3,
    M_DEC   = 3'd4,
    M_HEX   = 3'd5
  } mode_e;

  mode_e              mode_q, mode_d;
  logic [7:0]         held_q, held_d;
  logic               hvalid_q, hvalid_d;
  logic               hstart_q, hstart_d;
  logic [TEXT_CW-1:0] tcount_q, tcount_d;
  logic [7:0]         tokens_q, tokens_d;
  logic [7:0]         limit_q;

  always_comb begin
    result_t    res [2];
    logic [1:0] n;
    logic       do_keep;
    logic       do_finish;
    logic       do_start;
    logic       do_clear;
    tok_kind_e  hkind;

    res[0]    = '0;
    res[1]    = '0;
    n         = 2'd0;
    do_keep   = 1'b0;
    do_finish = 1'b0;
    do_start  = 1'b0;
    do_clear  = 1'b0;
    hkind     = (mode_q == M_IDENT) ? TK_IDENT : TK_NUMBER;

    mode_d   = mode_q;
    held_d   = held_q;
    hvalid_d = hvalid_q;
    hstart_d = hstart_q;
    tcount_d = tcount_q;
    tokens_d = tokens_q;

    if (char_i == CH_NUL) begin
      do_finish = (mode_q != M_IDLE) && (mode_q != M_MINUS);
    end else begin
      case (mode_q)
        M_MINUS: begin
          if (is_dec(char_i)) begin
            mode_d  = M_DEC;
            do_keep = 1'b1;
          end else begin
            do_clear = 1'b1;
            do_start = 1'b1;
          end
        end
        M_IDENT: begin
          if (is_letter(char_i) || is_dec(char_i) || char_i == CH_UNDER) begin
            do_keep = 1'b1;
          end else begin
            do_finish = 1'b1;
            do_start  = 1'b1;
          end
        end
        M_ZERO: begin
          if (char_i == CH_LOW_X || char_i == CH_UP_X) begin
            mode_d  = M_HEX;
            do_keep = 1'b1;
          end else if (is_dec(char_i)) begin
            mode_d  = M_DEC;
            do_keep = 1'b1;
          end else begin
            do_finish = 1'b1;
            do_start  = 1'b1;
          end
        end
        M_DEC: begin
          if (is_dec(char_i)) begin
            do_keep = 1'b1;
          end else begin
            do_finish = 1'b1;
            do_start  = 1'b1;
          end
        end
        M_HEX: begin
          if (is_hexd(char_i)) begin
            do_keep = 1'b1;
          end else begin
            do_finish = 1'b1;
            do_start  = 1'b1;
          end
        end
        default: begin
          do_clear = 1'b1;
          do_start = 1'b1;
        end
      endcase
    end

    // emit held byte and hold the new one, unless the text is full
    if (do_keep && (tcount_q < TEXT_CW'(TEXT_BYTES - 1))) begin
      res[n[0]] = '{IK_TOKEN, hkind, held_q, hstart_q, 1'b0, tokens_q, 8'd0, 1'b0};
      n         = n + 2'd1;
      held_d    = char_i;
      hstart_d  = 1'b0;
      tcount_d  = tcount_q + TEXT_CW'(1);
    end

    if (do_finish) begin
      if (hvalid_q) begin
        res[n[0]] = '{IK_TOKEN, hkind, held_q, hstart_q, 1'b1, tokens_q, 8'd0, 1'b0};
        n         = n + 2'd1;
      end
      tokens_d = tokens_q + 8'd1;
      do_clear = 1'b1;
    end

    if (do_clear) begin
      mode_d   = M_IDLE;
      held_d   = '0;
      hvalid_d = 1'b0;
      hstart_d = 1'b0;
      tcount_d = '0;
    end

    if (do_start && (tokens_d < limit_q)) begin
      if (char_i == CH_COMMA || char_i == CH_COLON) begin
        res[n[0]] = '{IK_TOKEN, (char_i == CH_COMMA) ? TK_COMMA : TK_COLON, char_i,
                      1'b1, 1'b1, tokens_d, 8'd0, 1'b0};
        n         = n + 2'd1;
        tokens_d  = tokens_d + 8'd1;
      end else if (is_letter(char_i) || is_dec(char_i) || char_i == CH_MINUS) begin
        if (is_letter(char_i)) begin
          mode_d = M_IDENT;
        end else if (char_i == CH_ZERO) begin
          mode_d = M_ZERO;
        end else if (is_dec(char_i)) begin
          mode_d = M_DEC;
        end else begin
          mode_d = M_MINUS;
        end
        held_d   = char_i;
        hvalid_d = 1'b1;
        hstart_d = 1'b1;
        tcount_d = TEXT_CW'(1);
      end
    end

    // line end: summary, then return all line state to reset
    if (char_i == CH_NUL) begin
      res[n[0]] = '{IK_SUMMARY, TK_IDENT, 8'd0, 1'b0, 1'b0, 8'd0, tokens_d, 1'b0};
      n         = n + 2'd1;
      tokens_d  = 8'd0;
      mode_d    = M_IDLE;
      held_d    = '0;
      hvalid_d  = 1'b0;
      hstart_d  = 1'b0;
      tcount_d  = '0;
    end

    if (n == 2'd1) begin
      res[0].run_last = 1'b1;
    end else if (n == 2'd2) begin
      res[1].run_last = 1'b1;
    end

    emit_o.count = n;
    emit_o.r0    = res[0];
    emit_o.r1    = res[1];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q   <= M_IDLE;
      held_q   <= '0;
      hvalid_q <= 1'b0;
      hstart_q <= 1'b0;
      tcount_q <= '0;
      tokens_q <= '0;
      limit_q  <= LIMIT_RESET;
    end else begin
      if (cfg_we_i) begin
        limit_q <= cfg_wdata_i;
      end
      if (accept_i) begin
        mode_q   <= mode_d;
        held_q   <= held_d;
        hvalid_q <= hvalid_d;
        hstart_q <= hstart_d;
        tcount_q <= tcount_d;
        tokens_q <= tokens_d;
      end
    end
  end

endmodule

// File: hdl/assembly_line_tokenizer.sv
// Top level of the assembly line tokenizer: scanner plus four-entry result queue.
//
//   channel   dir  width   content
//   s_axis    in   8       source character, zero ends the line
//   m_axis    out  32+3+1  token bytes and end of line summaries
//   cfg       in   8       token limit write
//
// One character is taken per cycle while ready; each causes zero, one or two results.
// Results leave through a four-entry queue at one per cycle while the sink is ready, so a run of
// characters that each cause two results is limited by the output side.
// s_axis_tready_o is high while the queue has room for two results.
// Reset clears the scanner state and the queue and sets the limit to 16.
`timescale 1ns / 1ps

module assembly_line_tokenizer import alt_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [7:0]  cfg_wdata_i,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [7:0]  s_axis_tdata_i,   // character
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [31:0] m_axis_tdata_o,   // text_byte, token_first, token_final,
                                        // token_number, token_total, zero pad
  output logic [2:0]  m_axis_tuser_o,   // item_kind, token_kind
  output logic        m_axis_tlast_o    // run_last
);

  localparam int unsigned QDEPTH = 4;

  emit_t      emit;
  logic       accept;
  logic       pop;
  result_t    q_q [QDEPTH];
  result_t    q_d [QDEPTH];
  logic [2:0] cnt_q, cnt_d;
  logic [2:0] base;

  assign s_axis_tready_o = (cnt_q <= 3'd2);
  assign accept          = s_axis_tvalid_i && s_axis_tready_o;
  assign pop             = (cnt_q != 3'd0) && m_axis_tready_i;

  alt_lexer u_lexer (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_wdata_i(cfg_wdata_i),
    .accept_i   (accept),
    .char_i     (s_axis_tdata_i),
    .emit_o     (emit)
  );

  always_comb begin
    base = cnt_q - {2'd0, pop};
    for (int i = 0; i < QDEPTH; i++) begin
      q_d[i] = q_q[i];
      if (pop && (i < QDEPTH - 1)) begin
        q_d[i] = q_q[(i < QDEPTH - 1) ? i + 1 : i];
      end
      if (accept && (emit.count != 2'd0) && (3'(i) == base)) begin
        q_d[i] = emit.r0;
      end
      if (accept && (emit.count == 2'd2) && (3'(i) == base + 3'd1)) begin
        q_d[i] = emit.r1;
      end
    end
    cnt_d = base + (accept ? {1'b0, emit.count} : 3'd0);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else begin
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    for (int i = 0; i < QDEPTH; i++) begin
      q_q[i] <= q_d[i];
    end
  end

  assign m_axis_tvalid_o = (cnt_q != 3'd0);
  assign m_axis_tdata_o  = {6'd0, q_q[0].token_total, q_q[0].token_number,
                            q_q[0].token_final, q_q[0].token_first, q_q[0].text_byte};
  assign m_axis_tuser_o  = {q_q[0].token_kind, q_q[0].item_kind};
  assign m_axis_tlast_o  = q_q[0].run_last;

endmodule
